[hw/rtl/tcl_pkg.sv]
// tcl_pkg: shared types and codes for the text cursor layout block.
// Holds item kinds, draw operations, control characters, register
// indexes, controller states and the controller/datapath signal groups.
`timescale 1ns / 1ps

package tcl_pkg;

  // item kinds
  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_MOVE   = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_INLINE = 3'd3;
  localparam logic [2:0] KIND_BLOCK  = 3'd4;

  // draw operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_GLYPH  = 3'd1;
  localparam logic [2:0] OP_ERASE  = 3'd2;
  localparam logic [2:0] OP_BITMAP = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // control characters
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // register indexes (byte address / 4)
  localparam logic [1:0] CFG_MARGIN = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_SCALE  = 2'd2;

  // tab stops lie every 8 cells, i.e. 64 * scale pixels
  localparam int unsigned STOP_SHIFT = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;    // capture the accepted item and seed the remainder
    logic step;    // one restoring remainder step
    logic commit;  // update the cursor and load the result register
  } cmd_t;

  typedef struct packed {
    logic is_tab;    // item on the input is a tab character
    logic div_last;  // final remainder step in progress
  } status_t;

endpackage

[hw/rtl/tcl_if.sv]
// tcl_if: item and result channel interfaces for the text cursor layout.
// Each carries valid, ready and the payload; depends on nothing else.
`timescale 1ns / 1ps

interface tcl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  char_code;
  logic [11:0] goto_x;
  logic [11:0] goto_y;
  logic [11:0] bitmap_width;
  logic [11:0] bitmap_height;

  modport source (
    output valid, kind, char_code, goto_x, goto_y, bitmap_width, bitmap_height,
    input  ready
  );
  modport sink (
    input  valid, kind, char_code, goto_x, goto_y, bitmap_width, bitmap_height,
    output ready
  );
endinterface

interface tcl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  draw_op;
  logic [11:0] draw_x;
  logic [11:0] draw_y;
  logic [11:0] draw_w;
  logic [11:0] draw_h;
  logic [7:0]  glyph;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;

  modport source (
    output valid, draw_op, draw_x, draw_y, draw_w, draw_h, glyph, cursor_x, cursor_y,
    input  ready
  );
  modport sink (
    input  valid, draw_op, draw_x, draw_y, draw_w, draw_h, glyph, cursor_x, cursor_y,
    output ready
  );
endinterface

[hw/rtl/tcl_ctrl.sv]
// tcl_ctrl: sequencing state machine of the text cursor layout.
// Issues load, remainder-step and commit commands; owns the result valid flag.
// Depends on tcl_pkg.
`timescale 1ns / 1ps

module tcl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tcl_pkg::status_t status,
  output tcl_pkg::cmd_t    cmd
);
  import tcl_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.is_tab ? ST_DIV : ST_COMMIT;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = slot_free;
      end
      default: ;
    endcase
  end

  // hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/tcl_datapath.sv]
// tcl_datapath: cursor registers, item capture, tab remainder unit and
// result register of the text cursor layout. Depends on tcl_pkg.
`timescale 1ns / 1ps

module tcl_datapath #(
  parameter int unsigned COORD_MAX = 4095
) (
  input  logic             clk,
  input  logic             rst,
  input  tcl_pkg::cmd_t    cmd,
  output tcl_pkg::status_t status,
  input  logic [11:0]      left_margin,
  input  logic [11:0]      line_width,
  input  logic [4:0]       text_scale,
  input  logic [2:0]       kind,
  input  logic [7:0]       char_code,
  input  logic [11:0]      goto_x,
  input  logic [11:0]      goto_y,
  input  logic [11:0]      bitmap_width,
  input  logic [11:0]      bitmap_height,
  output logic [2:0]       draw_op,
  output logic [11:0]      draw_x,
  output logic [11:0]      draw_y,
  output logic [11:0]      draw_w,
  output logic [11:0]      draw_h,
  output logic [7:0]       glyph,
  output logic [11:0]      cursor_x,
  output logic [11:0]      cursor_y
);
  import tcl_pkg::*;

  localparam int unsigned CW   = $clog2(COORD_MAX + 1);
  localparam int unsigned SW   = ((CW > 12) ? CW : 12) + 1;
  localparam int unsigned QW   = CW - STOP_SHIFT;
  localparam int unsigned CNTW = (QW > 1) ? $clog2(QW) : 1;
  localparam logic [SW-1:0] CMAX = SW'(COORD_MAX);

  function automatic logic [CW-1:0] sat(input logic [SW-1:0] v);
    sat = (v > CMAX) ? CMAX[CW-1:0] : v[CW-1:0];
  endfunction

  logic [CW-1:0]   cur_x;
  logic [CW-1:0]   cur_y;

  // captured item
  logic [2:0]      it_kind;
  logic [7:0]      it_char;
  logic [11:0]     it_gx;
  logic [11:0]     it_gy;
  logic [11:0]     it_bw;
  logic [11:0]     it_bh;

  // tab remainder unit: offset / 64 is reduced modulo the scale bit by bit
  logic [QW-1:0]   quo;
  logic [4:0]      rem;
  logic [5:0]      off_lo;
  logic [CNTW-1:0] cnt;
  logic [5:0]      rem_shift;
  logic [CW-1:0]   offset;

  logic [4:0]      scale_eff;
  logic [7:0]      cell_px;
  logic [10:0]     stop;

  logic [CW-1:0]   x_next;
  logic [CW-1:0]   y_next;
  logic [2:0]      op_next;
  logic [SW-1:0]   dx_next;
  logic [SW-1:0]   dy_next;
  logic [11:0]     dw_next;
  logic [11:0]     dh_next;
  logic [7:0]      gl_next;
  logic [SW-1:0]   x_next_ext;
  logic [SW-1:0]   y_next_ext;

  assign scale_eff = (text_scale == 5'd0) ? 5'd1 : text_scale;
  assign cell_px   = {scale_eff, 3'b000};
  assign stop      = {scale_eff, 6'b000000};
  assign offset    = (SW'(cur_x) > SW'(left_margin)) ?
                     CW'(SW'(cur_x) - SW'(left_margin)) : '0;
  assign rem_shift = {rem, quo[QW-1]};

  assign status.is_tab   = (kind == KIND_CHAR) && (char_code == CH_TAB);
  assign status.div_last = (cnt == CNTW'(QW - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_kind <= kind;
      it_char <= char_code;
      it_gx   <= goto_x;
      it_gy   <= goto_y;
      it_bw   <= bitmap_width;
      it_bh   <= bitmap_height;
      quo     <= offset[CW-1:STOP_SHIFT];
      off_lo  <= offset[STOP_SHIFT-1:0];
      rem     <= '0;
      cnt     <= '0;
    end else if (cmd.step) begin
      quo <= quo << 1;
      cnt <= cnt + CNTW'(1);
      if (rem_shift >= {1'b0, scale_eff}) begin
        rem <= 5'(rem_shift - {1'b0, scale_eff});
      end else begin
        rem <= rem_shift[4:0];
      end
    end
  end

  always_comb begin
    logic [SW-1:0] x0;
    logic [SW-1:0] y0;
    logic [SW-1:0] cellw;
    logic [CW-1:0] msat;
    x0      = SW'(cur_x);
    y0      = SW'(cur_y);
    cellw   = SW'(cell_px);
    msat    = sat(SW'(left_margin));
    x_next  = cur_x;
    y_next  = cur_y;
    op_next = OP_NONE;
    dx_next = '0;
    dy_next = '0;
    dw_next = '0;
    dh_next = '0;
    gl_next = '0;
    unique case (it_kind)
      KIND_CHAR: begin
        unique case (it_char)
          CH_NL: begin
            x_next = msat;
            y_next = sat(y0 + cellw);
          end
          CH_CR: begin
            x_next = msat;
          end
          CH_TAB: begin
            x_next = sat(x0 + SW'(stop - {rem, off_lo}));
          end
          CH_BS: begin
            if (x0 > SW'(left_margin)) begin
              x_next  = (x0 > cellw) ? CW'(x0 - cellw) : '0;
              op_next = OP_ERASE;
              dx_next = SW'(x_next);
              dy_next = y0;
              dw_next = 12'(cell_px);
              dh_next = 12'(cell_px);
            end
          end
          default: begin
            op_next = OP_GLYPH;
            dx_next = x0;
            dy_next = y0;
            dw_next = 12'(cell_px);
            dh_next = 12'(cell_px);
            gl_next = it_char;
            x_next  = sat(x0 + cellw);
          end
        endcase
        // soft wrap when the next cell would pass the line end
        if (SW'(x_next) + cellw > SW'(left_margin) + SW'(line_width)) begin
          x_next = msat;
          y_next = sat(SW'(y_next) + cellw);
        end
      end
      KIND_MOVE: begin
        x_next = sat(SW'(it_gx));
        y_next = sat(SW'(it_gy));
      end
      KIND_CLEAR: begin
        op_next = OP_CLEAR;
        x_next  = msat;
        y_next  = '0;
      end
      KIND_INLINE: begin
        op_next = OP_BITMAP;
        dx_next = x0;
        dy_next = y0;
        dw_next = it_bw;
        dh_next = it_bh;
        x_next  = sat(x0 + SW'(it_bw));
      end
      KIND_BLOCK: begin
        op_next = OP_BITMAP;
        dx_next = x0;
        dy_next = y0;
        dw_next = it_bw;
        dh_next = it_bh;
        y_next  = sat(y0 + SW'(it_bh));
        x_next  = msat;
      end
      default: ;
    endcase
  end

  assign x_next_ext = SW'(x_next);
  assign y_next_ext = SW'(y_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
    end else if (cmd.commit) begin
      cur_x <= x_next;
      cur_y <= y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      draw_op  <= op_next;
      draw_x   <= dx_next[11:0];
      draw_y   <= dy_next[11:0];
      draw_w   <= dw_next;
      draw_h   <= dh_next;
      glyph    <= gl_next;
      cursor_x <= x_next_ext[11:0];
      cursor_y <= y_next_ext[11:0];
    end
  end

endmodule

[hw/rtl/text_cursor_layout.sv]
// Text cursor layout: one draw command and cursor position per item.
// Each item is captured on transfer in and committed to the registered result;
// a tab first passes through the bit-serial tab remainder steps.
// No new item is taken until the current one is committed;
// a result still waiting for its transfer holds back the next commit.
// Reset (rst, synchronous): cursor at 0,0, margin 0, width 4095, scale 1.
`timescale 1ns / 1ps

module text_cursor_layout #(
  parameter int unsigned COORD_MAX = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tcl_in_if.sink      item,
  tcl_out_if.source   result
);
  import tcl_pkg::*;

  logic [11:0] left_margin;
  logic [11:0] line_width;
  logic [4:0]  text_scale;
  logic        cfg_write;
  logic [1:0]  cfg_sel;

  cmd_t    cmd;
  status_t status;

  assign pready    = 1'b1;
  assign cfg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_margin <= 12'd0;
      line_width  <= 12'd4095;
      text_scale  <= 5'd1;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        CFG_MARGIN: left_margin <= pwdata[11:0];
        CFG_WIDTH:  line_width  <= pwdata[11:0];
        CFG_SCALE:  text_scale  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CFG_MARGIN: prdata = {20'd0, left_margin};
      CFG_WIDTH:  prdata = {20'd0, line_width};
      CFG_SCALE:  prdata = {27'd0, text_scale};
      default:    prdata = 32'd0;
    endcase
  end

  tcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcl_datapath #(
    .COORD_MAX (COORD_MAX)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .left_margin   (left_margin),
    .line_width    (line_width),
    .text_scale    (text_scale),
    .kind          (item.kind),
    .char_code     (item.char_code),
    .goto_x        (item.goto_x),
    .goto_y        (item.goto_y),
    .bitmap_width  (item.bitmap_width),
    .bitmap_height (item.bitmap_height),
    .draw_op       (result.draw_op),
    .draw_x        (result.draw_x),
    .draw_y        (result.draw_y),
    .draw_w        (result.draw_w),
    .draw_h        (result.draw_h),
    .glyph         (result.glyph),
    .cursor_x      (result.cursor_x),
    .cursor_y      (result.cursor_y)
  );

  // a commit always presents a result on the next cycle
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> result.valid)
    else $error("commit did not raise result valid");

  // one item in flight: no transfer in directly after another
  assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item accepted while previous item still in work");

  // a result with no draw operation, or a clear, carries no area and no glyph
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.draw_op == OP_NONE || result.draw_op == OP_CLEAR)) |->
    (result.draw_w == 12'd0 && result.draw_h == 12'd0 && result.glyph == 8'd0))
    else $error("idle or clear result carries draw data");

endmodule
